// File: rtl/packbits_encoder_assert.svh
// Assertion macros used by the encoder RTL.
`ifndef PACKBITS_ENCODER_ASSERT_SVH
`define PACKBITS_ENCODER_ASSERT_SVH

// Check a condition in the same cycle as its trigger.
`define PBE_ASSERT_NOW(label, trig, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (expr)) \
    else $error(msg);

// Check a condition in the cycle after its trigger.
`define PBE_ASSERT_NEXT(label, trig, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) \
    else $error(msg);

`endif

// File: rtl/pbe_pkg.sv
// Types and constants of the PackBits encoder.
package pbe_pkg;

  localparam int MAX_GROUP_DEF = 32;
  localparam logic [7:0] END_MARK = 8'd128;
  localparam logic [8:0] RUN_BASE = 9'd257;

  typedef enum logic [1:0] {
    MODE_EMPTY,
    MODE_SINGLE,
    MODE_RUN,
    MODE_LIT
  } pbe_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN_HDR,
    ST_RUN_VAL,
    ST_LIT_HDR,
    ST_LIT_DATA,
    ST_UPDATE,
    ST_FIN,
    ST_MARK
  } pbe_state_t;

endpackage

// File: rtl/packbits_encoder.sv
// Streaming PackBits encoder: one raw byte per input beat, encoded bytes out.
//
// Each input beat carries one raw byte and a flag on the final byte of a
// stream. The encoder keeps one pending group, either a run of equal bytes or
// a literal of differing bytes, of at most MAX_GROUP bytes. A run is sent as
// the header 257 minus its length and then the byte; a literal as its length
// minus one and then its bytes. When a literal meets a repeat of its last
// byte, that byte leaves the literal and opens a run of two. On the final
// byte the pending group is flushed and the end marker 128 follows, flagged
// on out_stream_end; out_item_done marks the last output beat caused by each
// input beat. A byte that only extends the pending group leaves the encoder
// idle, so the next byte may follow at once. A byte that closes a group
// holds the input while the group goes out, header plus data; a final byte
// also holds it for the flush of the pending group and the end marker. The
// output sequencer sends one byte per cycle while out_stall is low, and reads
// the literal bytes from a store with one read port and a registered read.
// The literal store needs no clearing after reset: only entries written for
// the current group are read.
module packbits_encoder
  import pbe_pkg::*;
#(
  parameter int MAX_GROUP = MAX_GROUP_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_item_done,
  output logic       out_stream_end
);

  `include "packbits_encoder_assert.svh"

  // Count holds up to MAX_GROUP itself; index covers the store depth.
  localparam int CW = $clog2(MAX_GROUP + 1);
  localparam int IW = $clog2(MAX_GROUP);

  // Sequencer and group state
  pbe_state_t     state_r, state_nxt;
  pbe_mode_t      mode_r, mode_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [7:0]     last_val_r, last_val_nxt;

  // Beat being worked on and the flush in progress
  logic [7:0]     byte_r, byte_nxt;
  logic           last_r, last_nxt;
  logic           to_run_r, to_run_nxt;   // after the flush, open a run of two
  logic           phase_r, phase_nxt;     // 0: flush caused by the byte, 1: final flush
  logic [CW-1:0]  fl_cnt_r, fl_cnt_nxt;
  logic [CW-1:0]  emit_idx_r, emit_idx_nxt;

  // Output register
  logic           out_valid_r;
  logic [7:0]     out_byte_r;
  logic           out_done_r;
  logic           out_end_r;

  // Literal store
  logic [7:0]     lit_mem [MAX_GROUP];
  logic [7:0]     rd_data_r;
  logic           mem_we;
  logic [IW-1:0]  mem_wa;
  logic [7:0]     mem_wd;
  logic           mem_re;
  logic [IW-1:0]  mem_ra;

  logic           accept;
  logic           load;
  logic           flush_need;
  logic           same;
  logic           push;
  logic [7:0]     push_byte;
  logic           push_done;
  logic           push_end;
  logic [CW-1:0]  emit_next;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  // The output register takes a beat when empty or when its beat leaves now.
  assign load     = !out_valid_r || !out_stall;
  assign same     = (in_byte == last_val_r);
  assign emit_next = emit_idx_r + CW'(1);

  // Does the incoming byte close the pending group?
  always_comb begin
    flush_need = 1'b0;
    unique case (mode_r)
      MODE_RUN: flush_need = !(same && (count_r < CW'(MAX_GROUP)));
      MODE_LIT: flush_need = same || (count_r >= CW'(MAX_GROUP));
      default:  flush_need = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    mode_nxt     = mode_r;
    count_nxt    = count_r;
    last_val_nxt = last_val_r;
    byte_nxt     = byte_r;
    last_nxt     = last_r;
    to_run_nxt   = to_run_r;
    phase_nxt    = phase_r;
    fl_cnt_nxt   = fl_cnt_r;
    emit_idx_nxt = emit_idx_r;
    mem_we       = 1'b0;
    mem_wa       = '0;
    mem_wd       = in_byte;
    mem_re       = 1'b0;
    mem_ra       = '0;
    push         = 1'b0;
    push_byte    = 8'd0;
    push_done    = 1'b0;
    push_end     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          byte_nxt  = in_byte;
          last_nxt  = in_last;
          phase_nxt = 1'b0;
          unique case (mode_r)
            MODE_EMPTY: begin
              mode_nxt     = MODE_SINGLE;
              count_nxt    = CW'(1);
              last_val_nxt = in_byte;
              mem_we       = 1'b1;
            end
            MODE_SINGLE: begin
              count_nxt = CW'(2);
              if (same) begin
                mode_nxt = MODE_RUN;
              end else begin
                mode_nxt     = MODE_LIT;
                last_val_nxt = in_byte;
                mem_we       = 1'b1;
                mem_wa       = IW'(1);
              end
            end
            MODE_RUN: begin
              if (!flush_need) begin
                count_nxt = count_r + CW'(1);
              end else begin
                fl_cnt_nxt = count_r;
                to_run_nxt = 1'b0;
                state_nxt  = ST_RUN_HDR;
              end
            end
            MODE_LIT: begin
              if (same) begin
                // Last literal byte moves into the new run.
                fl_cnt_nxt = count_r - CW'(1);
                to_run_nxt = 1'b1;
                state_nxt  = ST_LIT_HDR;
              end else if (flush_need) begin
                fl_cnt_nxt = count_r;
                to_run_nxt = 1'b0;
                state_nxt  = ST_LIT_HDR;
              end else begin
                mem_we       = 1'b1;
                mem_wa       = count_r[IW-1:0];
                count_nxt    = count_r + CW'(1);
                last_val_nxt = in_byte;
              end
            end
            default: ;
          endcase
          if (!flush_need && in_last) begin
            state_nxt = ST_FIN;
          end
        end
      end

      ST_RUN_HDR: begin
        if (load) begin
          push      = 1'b1;
          push_byte = 8'(RUN_BASE - 9'(fl_cnt_r));
          state_nxt = ST_RUN_VAL;
        end
      end

      ST_RUN_VAL: begin
        if (load) begin
          push      = 1'b1;
          push_byte = last_val_r;
          push_done = !phase_r && !last_r;
          state_nxt = phase_r ? ST_MARK : ST_UPDATE;
        end
      end

      ST_LIT_HDR: begin
        // Prefetch the first literal byte.
        mem_re = 1'b1;
        if (load) begin
          push         = 1'b1;
          push_byte    = 8'(fl_cnt_r - CW'(1));
          emit_idx_nxt = '0;
          state_nxt    = ST_LIT_DATA;
        end
      end

      ST_LIT_DATA: begin
        if (load) begin
          push      = 1'b1;
          push_byte = rd_data_r;
          if (emit_next == fl_cnt_r) begin
            push_done = !phase_r && !last_r;
            state_nxt = phase_r ? ST_MARK : ST_UPDATE;
          end else begin
            mem_re       = 1'b1;
            mem_ra       = emit_next[IW-1:0];
            emit_idx_nxt = emit_next;
          end
        end
      end

      ST_UPDATE: begin
        if (to_run_r) begin
          mode_nxt  = MODE_RUN;
          count_nxt = CW'(2);
        end else begin
          mode_nxt     = MODE_SINGLE;
          count_nxt    = CW'(1);
          last_val_nxt = byte_r;
          mem_we       = 1'b1;
          mem_wd       = byte_r;
        end
        state_nxt = last_r ? ST_FIN : ST_IDLE;
      end

      ST_FIN: begin
        phase_nxt = 1'b1;
        unique case (mode_r)
          MODE_RUN: begin
            fl_cnt_nxt = count_r;
            state_nxt  = ST_RUN_HDR;
          end
          MODE_LIT: begin
            fl_cnt_nxt = count_r;
            state_nxt  = ST_LIT_HDR;
          end
          MODE_SINGLE: begin
            // Lone byte goes out as a literal of one.
            fl_cnt_nxt = CW'(1);
            state_nxt  = ST_LIT_HDR;
          end
          default: state_nxt = ST_MARK;
        endcase
      end

      ST_MARK: begin
        if (load) begin
          push      = 1'b1;
          push_byte = END_MARK;
          push_done = 1'b1;
          push_end  = 1'b1;
          mode_nxt  = MODE_EMPTY;
          count_nxt = '0;
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      mode_r     <= MODE_EMPTY;
      count_r    <= '0;
      last_val_r <= 8'd0;
    end else begin
      state_r    <= state_nxt;
      mode_r     <= mode_nxt;
      count_r    <= count_nxt;
      last_val_r <= last_val_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    last_r     <= last_nxt;
    to_run_r   <= to_run_nxt;
    phase_r    <= phase_nxt;
    fl_cnt_r   <= fl_cnt_nxt;
    emit_idx_r <= emit_idx_nxt;
  end

  // Literal store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      lit_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= lit_mem[mem_ra];
    end
  end

  // Output register: hold while stalled, drop once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_byte_r <= push_byte;
      out_done_r <= push_done;
      out_end_r  <= push_end;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_item_done  = out_done_r;
  assign out_stream_end = out_end_r;

  `PBE_ASSERT_NOW(a_count_cap, 1'b1, count_r <= CW'(MAX_GROUP), "group exceeds cap")
  `PBE_ASSERT_NOW(a_lit_len, mode_r == MODE_LIT, count_r >= CW'(2), "literal too short")
  `PBE_ASSERT_NOW(a_emit_range, state_r == ST_LIT_DATA, emit_idx_r < fl_cnt_r, "index past length")
  `PBE_ASSERT_NEXT(a_grow_ready, accept && !flush_need && !in_last, !in_stall, "grow stalled input")
  `PBE_ASSERT_NOW(a_end_done, out_valid_r && out_end_r, out_done_r, "end marker not done")

endmodule

// File: dv/tb_top.sv
// Self-checking bench for the streaming PackBits encoder, with its own encoder model.
module tb_top;
  import pbe_pkg::*;

  // Group cap of the instance; the encoder is built with its default.
  localparam int GROUP_CAP    = MAX_GROUP_DEF;
  // Cycles without any accepted beat before the run is abandoned.
  localparam int QUIET_LIMIT  = 1000;
  // Cycles to keep watching once every expected byte has arrived.
  localparam int DRAIN_CYCLES = 40;
  // Length of the long receiver hold-off.
  localparam int HOLD_CYCLES  = 200;

  // One encoded output beat as the model predicts it.
  typedef struct packed {
    logic [7:0] data;
    logic       item_done;
    logic       stream_end;
  } coded_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_item_done;
  logic       out_stream_end;

  packbits_encoder u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_item_done  (out_item_done),
    .out_stream_end (out_stream_end)
  );

  // Encoder model state: pending group, its length, its newest byte and the
  // bytes of a pending literal.
  pbe_mode_t   grp_mode = MODE_EMPTY;
  int unsigned grp_len  = 0;
  logic [7:0]  grp_tail = 8'd0;
  logic [7:0]  lit_bytes [GROUP_CAP];

  // Encoded bytes still owed by the encoder, oldest first.
  coded_t      coded_q [$];
  // Raw bytes of the stream being assembled by a test.
  logic [7:0]  stream_q [$];

  int          mismatches  = 0;
  int          quiet_cycles = 0;
  bit          idle_on     = 1'b1;
  int          stall_left  = 0;
  int          hold_req    = 0;
  int          hold_left   = 0;

  // Free-running clock, period 12.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Encoder model
  // ---------------------------------------------------------------------------

  // Append one encoded byte to the expected stream.
  function automatic void emit(input logic [7:0] d, input logic mark);
    coded_t c;
    c.data       = d;
    c.item_done  = 1'b0;
    c.stream_end = mark;
    coded_q = {coded_q, c};
  endfunction

  // Close a run: header 257 minus the length, then the repeated byte.
  function automatic void emit_run();
    logic [8:0] hdr;
    hdr = RUN_BASE - 9'(grp_len);
    emit(hdr[7:0], 1'b0);
    emit(grp_tail, 1'b0);
  endfunction

  // Close a literal of n bytes: header n-1, then the bytes in order.
  function automatic void emit_literal(input int unsigned n);
    int unsigned k;
    if (n > GROUP_CAP) n = GROUP_CAP;
    if (n == 0) return;
    emit(8'(n - 1), 1'b0);
    for (k = 0; k < n; k++) emit(lit_bytes[k], 1'b0);
  endfunction

  function automatic void open_single(input logic [7:0] b);
    grp_mode     = MODE_SINGLE;
    grp_len      = 1;
    grp_tail     = b;
    lit_bytes[0] = b;
  endfunction

  // Advance the model by one raw byte and queue the bytes it must produce.
  function automatic void encode_byte(input logic [7:0] b, input logic fin);
    int unsigned owed_before;
    owed_before = coded_q.size();
    case (grp_mode)
      MODE_SINGLE: begin
        if (b == grp_tail) begin
          grp_mode = MODE_RUN;
          grp_len  = 2;
        end else begin
          grp_mode     = MODE_LIT;
          grp_len      = 2;
          lit_bytes[1] = b;
          grp_tail     = b;
        end
      end
      MODE_RUN: begin
        if (b == grp_tail && grp_len < GROUP_CAP) begin
          grp_len++;
        end else begin
          emit_run();
          open_single(b);
        end
      end
      MODE_LIT: begin
        // A repeat pulls the literal's last byte out into a run of two.
        if (b == grp_tail) begin
          emit_literal(grp_len - 1);
          grp_mode = MODE_RUN;
          grp_len  = 2;
        end else if (grp_len >= GROUP_CAP) begin
          emit_literal(grp_len);
          open_single(b);
        end else begin
          lit_bytes[grp_len] = b;
          grp_len++;
          grp_tail = b;
        end
      end
      default: open_single(b);
    endcase
    // Final byte: flush whatever is pending, then the end marker.
    if (fin) begin
      if (grp_mode == MODE_RUN) emit_run();
      else if (grp_mode == MODE_LIT) emit_literal(grp_len);
      else if (grp_mode == MODE_SINGLE) emit_literal(1);
      emit(END_MARK, 1'b1);
      grp_mode = MODE_EMPTY;
      grp_len  = 0;
    end
    // Flag the last byte this input caused.
    if (coded_q.size() > owed_before) coded_q[coded_q.size() - 1].item_done = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: predict on every accepted input beat, check every output beat.
  // Both live in one process so a same-edge input and output cannot race.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    coded_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) encode_byte(in_byte, in_last);
      if (out_valid && !out_stall) begin
        if (coded_q.size() == 0) begin
          $display("%0t: unexpected output beat, expected none, actual byte %0d", $time,
                   out_byte);
          mismatches++;
        end else begin
          want = coded_q.pop_front();
          if (out_byte !== want.data) begin
            $display("%0t: out_byte expected %0d actual %0d", $time, want.data, out_byte);
            mismatches++;
          end
          if (out_item_done !== want.item_done) begin
            $display("%0t: out_item_done expected %0b actual %0b", $time, want.item_done,
                     out_item_done);
            mismatches++;
          end
          if (out_stream_end !== want.stream_end) begin
            $display("%0t: out_stream_end expected %0b actual %0b", $time, want.stream_end,
                     out_stream_end);
            mismatches++;
          end
        end
        // Draw the receiver's pause before the next output beat.
        stall_left = idle_on ? $urandom_range(0, 6) : 0;
      end
    end
  end

  // Watchdog: abandon the run after too long with no beat moving either way.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Receiver: drive out_stall at the falling edge. A hold-off request takes
  // priority and is counted down here; otherwise spend the drawn pause.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Offer one raw byte: optional gap with valid low, then hold the beat until
  // it is accepted. Returns just after the accepting rising edge.
  task automatic send_beat(input logic [7:0] b, input logic fin);
    int gap;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= fin;
    do @(posedge clk); while (in_stall);
  endtask

  // Send the assembled stream, flagging its final byte.
  task automatic send_stream();
    int i;
    for (i = 0; i < stream_q.size(); i++) send_beat(stream_q[i], i == stream_q.size() - 1);
  endtask

  // Assemble a stream from runs, literals with differing neighbours and
  // repeat-heavy noise. Lengths are mostly short, sometimes past the cap.
  task automatic build_stream();
    int segs;
    int len;
    int kind;
    int i;
    logic [7:0] v;
    stream_q.delete();
    segs = $urandom_range(1, 6);
    repeat (segs) begin
      kind = $urandom_range(0, 9);
      len  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, GROUP_CAP + 8)
                                         : $urandom_range(1, 6);
      v    = 8'($urandom_range(0, 255));
      for (i = 0; i < len; i++) begin
        if (kind < 4) begin
          stream_q = {stream_q, v};
        end else if (kind < 8) begin
          stream_q = {stream_q, v};
          v = v + 8'($urandom_range(1, 255));
        end else begin
          stream_q = {stream_q, ($urandom_range(0, 1) ? 8'($urandom_range(0, 2))
                                                      : 8'($urandom_range(0, 255)))};
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked streams: lone bytes at both byte extremes, a plain run, a
  // literal broken by a repeat, a literal flushed at the end, a run closed by
  // a differing byte, and an alternating pattern.
  task automatic test_directed();
    idle_on = 1'b1;
    send_beat(8'h00, 1'b1);
    send_beat(8'hFF, 1'b1);
    send_beat(8'hA5, 1'b0);
    send_beat(8'hA5, 1'b0);
    send_beat(8'hA5, 1'b1);
    send_beat(8'h01, 1'b0);
    send_beat(8'h02, 1'b0);
    send_beat(8'h03, 1'b0);
    send_beat(8'h03, 1'b0);
    send_beat(8'h04, 1'b1);
    send_beat(8'h10, 1'b0);
    send_beat(8'h20, 1'b0);
    send_beat(8'h30, 1'b1);
    send_beat(8'h7E, 1'b0);
    send_beat(8'h7E, 1'b0);
    send_beat(8'h81, 1'b1);
    send_beat(8'h55, 1'b0);
    send_beat(8'hAA, 1'b0);
    send_beat(8'h55, 1'b0);
    send_beat(8'hAA, 1'b1);
  endtask

  // Runs and literals that hit the group cap: a run one past the cap, literals
  // filled to the cap and closed by a differing byte, a literal of two met by a
  // repeat, and a run of exactly the cap ending the stream.
  task automatic test_group_limits();
    logic [7:0] v;
    idle_on = 1'b1;
    stream_q.delete();
    v = 8'($urandom_range(0, 255));
    repeat (GROUP_CAP + 1) stream_q = {stream_q, v};
    v = v + 8'($urandom_range(1, 255));
    repeat (GROUP_CAP + 1) begin
      stream_q = {stream_q, v};
      v = v + 8'($urandom_range(1, 255));
    end
    repeat (GROUP_CAP) begin
      stream_q = {stream_q, v};
      v = v + 8'($urandom_range(1, 255));
    end
    stream_q = {stream_q, stream_q[stream_q.size() - 1]};
    stream_q = {stream_q, v};
    send_stream();
    stream_q.delete();
    v = 8'($urandom_range(0, 255));
    repeat (GROUP_CAP) stream_q = {stream_q, v};
    send_stream();
  endtask

  // Random streams, idling on most of them and none on the rest.
  task automatic test_random_streams(input int n_items);
    int sent;
    sent = 0;
    while (sent < n_items) begin
      idle_on = ($urandom_range(0, 3) != 0);
      build_stream();
      send_stream();
      sent += stream_q.size();
    end
  endtask

  // Hold the receiver off for a long stretch while bytes keep coming, so the
  // encoder fills and stalls its input.
  task automatic test_backpressure();
    int sent;
    idle_on = 1'b0;
    send_beat(8'($urandom_range(0, 255)), 1'b0);
    hold_req = HOLD_CYCLES;
    sent = 1;
    while (sent < 40) begin
      build_stream();
      send_stream();
      sent += stream_q.size();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_byte  = 8'd0;
    in_last  = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_group_limits();
    test_backpressure();
    test_random_streams(230);

    // Drop valid, wait for every owed byte, then watch a little longer for
    // anything extra.
    @(negedge clk);
    in_valid <= 1'b0;
    while (coded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && coded_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/pbe_pkg.sv
rtl/packbits_encoder.sv
dv/tb_top.sv
